// ----- hdl/rc_pulse_capture_decoder_defines.svh -----
// Assertion macros shared by the RC pulse capture decoder.
`ifndef RC_PULSE_CAPTURE_DECODER_DEFINES_SVH
`define RC_PULSE_CAPTURE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RCPD_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RCPD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/rcpd_pkg.sv -----
// Shared types and constants of the RC pulse capture decoder.
package rcpd_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int THR_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int POS_W       = 8;

  // The dividend is the offset scaled by 16, the divisor is the span over 8.
  localparam int DIVD_W    = TIMER_WIDTH + 4;
  localparam int DIVR_W    = TIMER_WIDTH - 3;
  localparam int DIV_STEPS = DIVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_CENTER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_THR   = 3'd4;

  localparam logic [TIMER_WIDTH-1:0] RST_PULSE_MIN    = 16'd1500;
  localparam logic [TIMER_WIDTH-1:0] RST_PULSE_CENTER = 16'd2250;
  localparam logic [TIMER_WIDTH-1:0] RST_PULSE_MAX    = 16'd3000;
  localparam logic [TIMER_WIDTH-1:0] RST_PERIOD_TOP   = 16'd29999;
  localparam logic [THR_W-1:0]       RST_SWITCH_THR   = 7'd85;

  typedef enum logic [1:0] {
    SW_ERROR  = 2'd0,
    SW_UP     = 2'd1,
    SW_MIDDLE = 2'd2,
    SW_DOWN   = 2'd3
  } switch_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic store_start;
    logic load_width;
    logic prep;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
    logic out_busy;
  } status_t;

endpackage

// ----- hdl/rcpd_ctrl.sv -----
// Controller state machine of the RC pulse capture decoder.
module rcpd_ctrl
  import rcpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t           state;
  state_t           state_next;
  logic             expect_rising;
  logic [CNT_W-1:0] step_cnt;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      expect_rising <= 1'b1;
      step_cnt      <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        expect_rising <= !expect_rising;
      end
      if (state == S_PREP) begin
        step_cnt <= '0;
      end else if (state == S_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !expect_rising) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = status.skip_div ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (step_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready        = 1'b1;
        cmd.store_start = accept && expect_rising;
        cmd.load_width  = accept && !expect_rising;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- hdl/rcpd_dpath.sv -----
// Datapath of the RC pulse capture decoder: settings, width, divider, result register.
module rcpd_dpath
  import rcpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TIMER_WIDTH-1:0] cfg_data,
  input  logic [TIMER_WIDTH-1:0] capture_time,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [TIMER_WIDTH-1:0] pulse_width,
  output logic signed [POS_W-1:0] position,
  output logic [1:0]             switch_state,
  output logic                   pulse_invalid
);

  logic [TIMER_WIDTH-1:0] pulse_min;
  logic [TIMER_WIDTH-1:0] pulse_center;
  logic [TIMER_WIDTH-1:0] pulse_max;
  logic [TIMER_WIDTH-1:0] period_top;
  logic [THR_W-1:0]       switch_threshold;

  logic [TIMER_WIDTH-1:0] start_time;
  logic [TIMER_WIDTH-1:0] width;
  logic [TIMER_WIDTH-1:0] width_next;

  logic                   bad;
  logic                   left;
  logic [DIVR_W-1:0]      divisor;
  logic [DIVR_W-1:0]      rem;
  logic [DIVD_W-1:0]      dq;

  // Setup logic, evaluated on the registered width.
  logic                   range_bad;
  logic                   at_center;
  logic                   left_side;
  logic [TIMER_WIDTH-1:0] offset;
  logic [TIMER_WIDTH-1:0] span;
  logic [DIVR_W-1:0]      div_val;
  logic                   bad_next;
  logic                   skip;

  logic [DIVR_W:0]        trial;

  logic                   sat;
  logic [POS_W-1:0]       pos_val;
  logic signed [POS_W:0]  pos_ext;
  logic signed [POS_W:0]  thr_ext;
  switch_t                sw_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min        <= RST_PULSE_MIN;
      pulse_center     <= RST_PULSE_CENTER;
      pulse_max        <= RST_PULSE_MAX;
      period_top       <= RST_PERIOD_TOP;
      switch_threshold <= RST_SWITCH_THR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PULSE_MIN:    pulse_min        <= cfg_data;
        CFG_PULSE_CENTER: pulse_center     <= cfg_data;
        CFG_PULSE_MAX:    pulse_max        <= cfg_data;
        CFG_PERIOD_TOP:   period_top       <= cfg_data;
        CFG_SWITCH_THR:   switch_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // When the counter rolled over during the pulse, the period top is added back.
  always_comb begin
    width_next = capture_time - start_time;
    if (capture_time < start_time) begin
      width_next = width_next + period_top;
    end
  end

  always_comb begin
    range_bad = (width < pulse_min) || (width > pulse_max);
    at_center = (width == pulse_center);
    left_side = (width < pulse_center);
    offset    = left_side ? (pulse_center - width) : (width - pulse_center);
    span      = left_side ? (pulse_center - pulse_min) : (pulse_max - pulse_center);
    div_val   = span[TIMER_WIDTH-1:3];
    bad_next  = range_bad || (!at_center && (div_val == '0));
    skip      = bad_next || at_center;
  end

  assign trial = {rem, dq[DIVD_W-1]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.store_start) begin
      start_time <= capture_time;
    end
    if (cmd.load_width) begin
      width <= width_next;
    end
    if (cmd.prep) begin
      bad     <= bad_next;
      left    <= left_side;
      divisor <= div_val;
      rem     <= '0;
      dq      <= skip ? '0 : {offset, 4'b0000};
    end else if (cmd.div_step) begin
      // One restoring division step: the quotient shifts in where the dividend leaves.
      if (!trial[DIVR_W]) begin
        rem <= trial[DIVR_W-1:0];
        dq  <= {dq[DIVD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DIVR_W-2:0], dq[DIVD_W-1]};
        dq  <= {dq[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sat = |dq[DIVD_W-1:POS_W-1];
    if (bad) begin
      pos_val = '0;
    end else if (left) begin
      pos_val = sat ? {1'b1, {(POS_W-1){1'b0}}} : (POS_W'(0) - {1'b0, dq[POS_W-2:0]});
    end else if (sat || (&dq[POS_W-2:0])) begin
      pos_val = {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_val = {1'b0, dq[POS_W-2:0]};
    end
    pos_ext = signed'({pos_val[POS_W-1], pos_val});
    thr_ext = signed'({2'b00, switch_threshold});
    if (bad) begin
      sw_val = SW_ERROR;
    end else if (pos_ext > thr_ext) begin
      sw_val = SW_DOWN;
    end else if (pos_ext < -thr_ext) begin
      sw_val = SW_UP;
    end else begin
      sw_val = SW_MIDDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pulse_width   <= width;
      position      <= signed'(pos_val);
      switch_state  <= sw_val;
      pulse_invalid <= bad;
    end
  end

  assign status.skip_div = skip;
  assign status.out_busy = out_valid && !out_ready;

endmodule

// ----- hdl/rc_pulse_capture_decoder.sv -----
// Top level of the RC pulse capture decoder.
//
//   channel   signals                                   direction
//   input     in_valid/in_ready, capture_time           in
//   output    out_valid/out_ready, pulse_width,         out
//             position, switch_state, pulse_invalid
//   config    cfg_wr_en, cfg_index, cfg_data            in, write only
//
// A rising-edge capture only stores the start time and gives no result.
// A falling-edge capture runs through accept, setup, 20 divider steps and finish;
// the divider is bit-serial. Out-of-range widths, zero spans and the center width skip it.
// The result sits in an output register, so the next transaction can be taken while it waits.
// A finished result stalls in the last step only while the previous one is still unread.
// Synchronous active-high reset loads the register defaults and expects a rising edge.
`include "rc_pulse_capture_decoder_defines.svh"

module rc_pulse_capture_decoder
  import rcpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [TIMER_WIDTH-1:0]  cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TIMER_WIDTH-1:0]  capture_time,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TIMER_WIDTH-1:0]  pulse_width,
  output logic signed [POS_W-1:0] position,
  output logic [1:0]              switch_state,
  output logic                    pulse_invalid
);

  cmd_t    cmd;
  status_t status;

  rcpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rcpd_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .capture_time  (capture_time),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pulse_width   (pulse_width),
    .position      (position),
    .switch_state  (switch_state),
    .pulse_invalid (pulse_invalid)
  );

  // An invalid pulse always reports a zero position and the error switch code.
  `RCPD_ASSERT_NOW(a_invalid_result, clk, rst, out_valid && pulse_invalid,
                   (position == '0) && (switch_state == SW_ERROR))
  // A valid pulse never reports the error switch code.
  `RCPD_ASSERT_NOW(a_valid_switch, clk, rst, out_valid && !pulse_invalid,
                   switch_state != SW_ERROR)
  // A new result is only written when the output register is free.
  `RCPD_ASSERT_NOW(a_no_overwrite, clk, rst, cmd.load_out, !out_valid || out_ready)
  // After a falling-edge transaction the block is busy measuring.
  `RCPD_ASSERT_NEXT(a_busy_after_fall, clk, rst, cmd.load_width, !in_ready)

endmodule

// ----- tb/pulse_decode_checker.sv -----
// Checker for the RC pulse capture decoder: predicts each decoded pulse and compares results.
module pulse_decode_checker
  import rcpd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [TIMER_WIDTH-1:0]  cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [TIMER_WIDTH-1:0]  capture_time,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [TIMER_WIDTH-1:0]  pulse_width,
  input  logic signed [POS_W-1:0] position,
  input  logic [1:0]              switch_state,
  input  logic                    pulse_invalid,
  output int                      errors,
  output int                      outstanding,
  output int                      decodes_checked
);

  typedef struct {
    logic [TIMER_WIDTH-1:0]  width;
    logic signed [POS_W-1:0] pos;
    switch_t                 sw;
    logic                    bad;
  } pulse_decode_t;

  logic [TIMER_WIDTH-1:0] min_w, center_w, max_w, wrap_top;
  logic [THR_W-1:0]       sw_thr;
  logic                   awaiting_rise;
  logic [TIMER_WIDTH-1:0] rise_time;

  pulse_decode_t expected_decodes[$];
  int fail_count = 0;
  int checked = 0;

  function automatic pulse_decode_t decode_pulse(input logic [TIMER_WIDTH-1:0] cap);
    pulse_decode_t d;
    logic [TIMER_WIDTH-1:0] w, off, span;
    logic [DIVR_W-1:0]      divisor;
    logic [DIVD_W-1:0]      quot;
    int                     pos, thr;
    // Width arithmetic is done at the timer width, so it wraps modulo 2^16.
    if (cap < rise_time) begin
      w = cap + wrap_top - rise_time;
    end else begin
      w = cap - rise_time;
    end
    d.width = w;
    d.bad = 1'b0;
    pos = 0;
    if (w < min_w || w > max_w) begin
      d.bad = 1'b1;
    end else if (w != center_w) begin
      if (w < center_w) begin
        off = center_w - w;
        span = center_w - min_w;
      end else begin
        off = w - center_w;
        span = max_w - center_w;
      end
      divisor = span[TIMER_WIDTH-1:3];
      if (divisor == 0) begin
        d.bad = 1'b1;
      end else begin
        quot = {off, 4'b0000} / divisor;
        if (w < center_w) begin
          pos = (quot >= 128) ? -128 : -int'(quot);
        end else begin
          pos = (quot >= 127) ? 127 : int'(quot);
        end
      end
    end
    d.pos = pos[POS_W-1:0];
    thr = int'(sw_thr);
    if (d.bad) begin
      d.sw = SW_ERROR;
    end else if (pos > thr) begin
      d.sw = SW_DOWN;
    end else if (pos < -thr) begin
      d.sw = SW_UP;
    end else begin
      d.sw = SW_MIDDLE;
    end
    return d;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("decode mismatch at %0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    pulse_decode_t want;
    if (rst) begin
      min_w = RST_PULSE_MIN;
      center_w = RST_PULSE_CENTER;
      max_w = RST_PULSE_MAX;
      wrap_top = RST_PERIOD_TOP;
      sw_thr = RST_SWITCH_THR;
      awaiting_rise = 1'b1;
      rise_time = '0;
      expected_decodes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PULSE_MIN:    min_w = cfg_data;
          CFG_PULSE_CENTER: center_w = cfg_data;
          CFG_PULSE_MAX:    max_w = cfg_data;
          CFG_PERIOD_TOP:   wrap_top = cfg_data;
          CFG_SWITCH_THR:   sw_thr = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_decodes.size() == 0) begin
          log_failure($sformatf("unexpected result width %0d position %0d switch %0d invalid %0b",
                                pulse_width, position, switch_state, pulse_invalid));
        end else begin
          want = expected_decodes.pop_front();
          checked++;
          if (pulse_width !== want.width || position !== want.pos ||
              switch_state !== want.sw || pulse_invalid !== want.bad) begin
            log_failure($sformatf({"expected width %0d position %0d switch %0d invalid %0b, ",
                                   "got width %0d position %0d switch %0d invalid %0b"},
                                  want.width, want.pos, want.sw, want.bad,
                                  pulse_width, position, switch_state, pulse_invalid));
          end
        end
      end
      // Edges alternate: a rising capture only records the start time.
      if (in_valid && in_ready) begin
        if (awaiting_rise) begin
          rise_time = capture_time;
          awaiting_rise = 1'b0;
        end else begin
          expected_decodes.push_back(decode_pulse(capture_time));
          awaiting_rise = 1'b1;
        end
      end
    end
    errors <= fail_count;
    outstanding <= expected_decodes.size();
    decodes_checked <= checked;
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the RC pulse capture decoder testbench: clock, reset, stimulus and verdict.
module testbench
  import rcpd_pkg::*;
();

  localparam int PHASES           = 8;
  localparam int RANDOM_PER_PHASE = 240;
  localparam int SETTLE_CYCLES    = 32;
  localparam int STALL_LIMIT      = 4000;
  localparam int CFG_FIRST_UNUSED = int'(CFG_SWITCH_THR) + 1;
  localparam int CFG_LAST_INDEX   = (1 << CFG_IDX_W) - 1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [TIMER_WIDTH-1:0]  cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [TIMER_WIDTH-1:0]  capture_time = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TIMER_WIDTH-1:0]  pulse_width;
  logic signed [POS_W-1:0] position;
  logic [1:0]              switch_state;
  logic                    pulse_invalid;

  int errors, outstanding, decodes_checked;

  // Register values as last written, used only to aim the stimulus.
  logic [TIMER_WIDTH-1:0] cur_min, cur_center, cur_max, cur_top;

  bit falling_next = 1'b0;
  bit steady_in = 1'b0;
  bit steady_out = 1'b0;
  int captures_sent = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rc_pulse_capture_decoder u_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready), .pulse_width(pulse_width),
    .position(position), .switch_state(switch_state), .pulse_invalid(pulse_invalid)
  );

  pulse_decode_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .capture_time(capture_time),
    .out_valid(out_valid), .out_ready(out_ready), .pulse_width(pulse_width),
    .position(position), .switch_state(switch_state), .pulse_invalid(pulse_invalid),
    .errors(errors), .outstanding(outstanding), .decodes_checked(decodes_checked)
  );

  // Result side: each transaction waits a random number of cycles before ready.
  always begin
    int stall;
    stall = steady_out ? 0 : $urandom_range(0, 9);
    if (stall > 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ready <= 1'b1;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid is lowered only when a gap is drawn or the bench waits for idle, so back-to-back captures keep it high.
  task automatic send_capture(input logic [TIMER_WIDTH-1:0] value);
    int gap;
    if (captures_sent % 32 == 0) begin
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
    end
    gap = steady_in ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    capture_time <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    captures_sent++;
    falling_next = !falling_next;
  endtask

  task automatic send_edges(input logic [TIMER_WIDTH-1:0] rise,
                            input logic [TIMER_WIDTH-1:0] fall);
    send_capture(rise);
    send_capture(fall);
  endtask

  function automatic int pick_width();
    int lo, hi;
    lo = int'(cur_min);
    if (cur_center < lo) lo = int'(cur_center);
    if (cur_max < lo) lo = int'(cur_max);
    hi = int'(cur_min);
    if (cur_center > hi) hi = int'(cur_center);
    if (cur_max > hi) hi = int'(cur_max);
    lo = (lo > 64) ? lo - 64 : 0;
    hi = (hi + 64 > 65535) ? 65535 : hi + 64;
    case ($urandom_range(0, 15))
      0: return int'(cur_min);
      1: return int'(cur_max);
      2: return int'(cur_center);
      3: return (int'(cur_center) + 1) & 16'hFFFF;
      4: return (int'(cur_center) - 1) & 16'hFFFF;
      5: return $urandom_range(0, 65535);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // A pulse of the given width, sometimes placed so the timer wraps through its top.
  task automatic send_pulse(input int w);
    int top, rise, fall;
    top = int'(cur_top);
    if (falling_next) send_capture(16'($urandom));
    if (w < top && $urandom_range(0, 3) == 0) begin
      rise = $urandom_range(top - w, top);
      fall = rise + w - top;
    end else begin
      rise = $urandom_range(0, 65535 - w);
      fall = rise + w;
    end
    send_edges(16'(rise), 16'(fall));
  endtask

  task automatic random_captures(input int count);
    int first;
    first = captures_sent;
    while (captures_sent - first < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_capture(16'($urandom));
      end else begin
        send_pulse(pick_width());
      end
    end
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIMER_WIDTH-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_phase(input int phase);
    int base;
    logic [TIMER_WIDTH-1:0] thr_data;
    logic [CFG_IDX_W-1:0]   spare_idx;
    case (phase)
      1: begin
        cur_min = 16'd0; cur_center = 16'd32768; cur_max = 16'hFFFF;
        cur_top = 16'hFFFF; thr_data = 16'd0;
      end
      2: begin
        // The left span is too narrow for the divider.
        cur_min = 16'd1000; cur_center = 16'd1007; cur_max = 16'd1300;
        cur_top = 16'd20000; thr_data = 16'd127;
      end
      3: begin
        // Center lies above max, so only the left side is reachable.
        cur_min = 16'd1500; cur_center = 16'd3500; cur_max = 16'd3000;
        cur_top = 16'd0; thr_data = 16'hFFD5;
      end
      4: begin
        cur_min = 16'd0; cur_center = 16'd0; cur_max = 16'd8;
        cur_top = 16'd1; thr_data = 16'h0001;
      end
      default: begin
        base = $urandom_range(0, 50000);
        cur_min = 16'(base);
        cur_center = 16'(base + $urandom_range(0, 3000));
        cur_max = 16'(int'(cur_center) + $urandom_range(0, 3000));
        cur_top = 16'($urandom_range(0, 65535));
        thr_data = 16'($urandom_range(0, 65535));
      end
    endcase
    spare_idx = CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX));
    write_reg(CFG_PULSE_MIN, cur_min);
    write_reg(CFG_PULSE_CENTER, cur_center);
    write_reg(CFG_PULSE_MAX, cur_max);
    write_reg(CFG_PERIOD_TOP, cur_top);
    write_reg(CFG_SWITCH_THR, thr_data);
    // Writes to unused indexes come last so a wrong decode would not be overwritten.
    write_reg(spare_idx, 16'($urandom));
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    cur_min = RST_PULSE_MIN;
    cur_center = RST_PULSE_CENTER;
    cur_max = RST_PULSE_MAX;
    cur_top = RST_PERIOD_TOP;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed pulses against the reset register values.
    send_edges(16'd0, 16'd2250);
    send_edges(16'd100, 16'd1600);
    send_edges(16'd62535, 16'd65535);
    send_edges(16'd5, 16'd1504);
    send_edges(16'd1000, 16'd4001);
    send_edges(16'd29000, 16'd1000);
    send_edges(16'd65535, 16'd0);
    send_edges(16'd777, 16'd777);
    send_edges(16'd0, 16'd2745);
    send_edges(16'd10, 16'd2760);
    send_edges(16'd20, 16'd1775);
    send_edges(16'd30, 16'd1780);

    random_captures(RANDOM_PER_PHASE);
    wait_until_idle();
    for (int phase = 1; phase < PHASES; phase++) begin
      load_phase(phase);
      random_captures(RANDOM_PER_PHASE);
      wait_until_idle();
    end

    $display("Sent %0d edge captures under %0d register settings; %0d decoded pulses checked.",
             captures_sent, PHASES, decodes_checked);
    $display("Settings included register extremes, out-of-order ranges and zero spans.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
